// ----- src/csp_pkg.sv -----
// Package for the Cayley spin precession block: fixed-point helpers, microcode,
// register-file addresses, state and unit request/response types.
// Depends on nothing; every other file but csp_ifs uses it.
`default_nettype none

package csp_pkg;

    localparam int FRAC_BITS        = 30;
    localparam int DEF_MAX_SUBSTEPS = 4096;
    localparam int WORD_W           = 64;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam word_t ONE  = word_t'(64'sd1 <<< FRAC_BITS);
    // dividend of the 2/(1+k.k) reciprocal in working units
    localparam logic [WORD_W-1:0] RECIP_NUM = 64'd1 << (2 * FRAC_BITS + 1);

    localparam logic signed [31:0] GAIN_RESET     = 32'sd348966093;
    localparam logic [31:0]        TIME_RESET     = 32'd268435456;
    localparam logic [12:0]        SUBSTEPS_RESET = 13'd256;

    typedef enum logic [1:0] {
        CFG_GAIN          = 2'd0,
        CFG_TOTAL_TIME    = 2'd1,
        CFG_SUBSTEP_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        R_B0, R_B1, R_B2, R_OM0, R_OM1, R_OM2, R_G, R_HH,
        R_K0, R_K1, R_K2, R_KK, R_S, R_C0, R_C1, R_C2,
        R_D0, R_D1, R_D2, R_T1
    } reg_addr_t;

    localparam int REG_COUNT = 20;

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_ADD1, OP_DIV
    } op_t;

    typedef struct packed {
        op_t       op;
        reg_addr_t dst;
        reg_addr_t sa;
        reg_addr_t sb;
    } uop_t;

    localparam int             PC_W    = 6;
    localparam logic [PC_W-1:0] PC_SELF = 6'd0;
    localparam logic [PC_W-1:0] PC_AXIS = 6'd1;
    localparam logic [PC_W-1:0] PC_LAST = 6'd37;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_HH_WAIT, ST_ISSUE, ST_EXEC,
        ST_MUL_WAIT, ST_DIV_WAIT, ST_OUT_RD, ST_OUT_CAP, ST_DONE
    } state_t;

    typedef struct packed {
        logic  sat;
        word_t val;
    } sres_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        logic  busy;
        logic  sat;
        word_t p;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] d;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] q;
    } div_rsp_t;

    // One substep of the rotation; entry 0 runs in self mode only.
    function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:    u = '{OP_MUL,  R_OM2, R_G,   R_B2};
            6'd1:    u = '{OP_MUL,  R_K0,  R_OM0, R_HH};
            6'd2:    u = '{OP_MUL,  R_K1,  R_OM1, R_HH};
            6'd3:    u = '{OP_MUL,  R_K2,  R_OM2, R_HH};
            6'd4:    u = '{OP_MUL,  R_KK,  R_K0,  R_K0};
            6'd5:    u = '{OP_MUL,  R_T1,  R_K1,  R_K1};
            6'd6:    u = '{OP_ADD,  R_KK,  R_KK,  R_T1};
            6'd7:    u = '{OP_MUL,  R_T1,  R_K2,  R_K2};
            6'd8:    u = '{OP_ADD,  R_KK,  R_KK,  R_T1};
            6'd9:    u = '{OP_ADD1, R_KK,  R_KK,  R_KK};
            6'd10:   u = '{OP_DIV,  R_S,   R_KK,  R_KK};
            6'd11:   u = '{OP_MUL,  R_C0,  R_K1,  R_B2};
            6'd12:   u = '{OP_MUL,  R_T1,  R_K2,  R_B1};
            6'd13:   u = '{OP_SUB,  R_C0,  R_C0,  R_T1};
            6'd14:   u = '{OP_MUL,  R_C1,  R_K2,  R_B0};
            6'd15:   u = '{OP_MUL,  R_T1,  R_K0,  R_B2};
            6'd16:   u = '{OP_SUB,  R_C1,  R_C1,  R_T1};
            6'd17:   u = '{OP_MUL,  R_C2,  R_K0,  R_B1};
            6'd18:   u = '{OP_MUL,  R_T1,  R_K1,  R_B0};
            6'd19:   u = '{OP_SUB,  R_C2,  R_C2,  R_T1};
            6'd20:   u = '{OP_MUL,  R_D0,  R_K1,  R_C2};
            6'd21:   u = '{OP_MUL,  R_T1,  R_K2,  R_C1};
            6'd22:   u = '{OP_SUB,  R_D0,  R_D0,  R_T1};
            6'd23:   u = '{OP_MUL,  R_D1,  R_K2,  R_C0};
            6'd24:   u = '{OP_MUL,  R_T1,  R_K0,  R_C2};
            6'd25:   u = '{OP_SUB,  R_D1,  R_D1,  R_T1};
            6'd26:   u = '{OP_MUL,  R_D2,  R_K0,  R_C1};
            6'd27:   u = '{OP_MUL,  R_T1,  R_K1,  R_C0};
            6'd28:   u = '{OP_SUB,  R_D2,  R_D2,  R_T1};
            6'd29:   u = '{OP_ADD,  R_D0,  R_C0,  R_D0};
            6'd30:   u = '{OP_MUL,  R_T1,  R_S,   R_D0};
            6'd31:   u = '{OP_ADD,  R_B0,  R_B0,  R_T1};
            6'd32:   u = '{OP_ADD,  R_D1,  R_C1,  R_D1};
            6'd33:   u = '{OP_MUL,  R_T1,  R_S,   R_D1};
            6'd34:   u = '{OP_ADD,  R_B1,  R_B1,  R_T1};
            6'd35:   u = '{OP_ADD,  R_D2,  R_C2,  R_D2};
            6'd36:   u = '{OP_MUL,  R_T1,  R_S,   R_D2};
            6'd37:   u = '{OP_ADD,  R_B2,  R_B2,  R_T1};
            default: u = '{OP_ADD,  R_T1,  R_T1,  R_T1};
        endcase
        return u;
    endfunction

    function automatic sres_t sadd(word_t a, word_t b);
        logic signed [WORD_W:0] s;
        logic signed [WORD_W:0] lim;
        sres_t r;
        lim = {1'b0, WMAX};
        s   = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
        if (s > lim) begin
            r = '{1'b1, WMAX};
        end else if (s < -lim) begin
            r = '{1'b1, -WMAX};
        end else begin
            r = '{1'b0, s[WORD_W-1:0]};
        end
        return r;
    endfunction

    // round-to-nearest right shift, ties away from zero
    function automatic word_t rshr(word_t v, int n);
        logic [WORD_W-1:0] m;
        word_t r;
        if (n <= 0) begin
            r = v;
        end else begin
            m = v[WORD_W-1] ? (~v + 64'd1) : v;
            m = (m + (64'd1 << (n - 1))) >> n;
            r = v[WORD_W-1] ? -$signed(m) : $signed(m);
        end
        return r;
    endfunction

    function automatic word_t to_work(word_t v, int nfrac);
        word_t r;
        if (FRAC_BITS >= nfrac) begin
            r = v <<< (FRAC_BITS - nfrac);
        end else begin
            r = rshr(v, nfrac - FRAC_BITS);
        end
        return r;
    endfunction

    function automatic sres_t to_q230(word_t v);
        word_t w;
        word_t lim;
        sres_t r;
        lim = word_t'(64'sd1 <<< 40);
        if (FRAC_BITS < 30) begin
            w = v;
            if (w > lim)  w = lim;
            if (w < -lim) w = -lim;
            w = w <<< (30 - FRAC_BITS);
        end else begin
            w = rshr(v, FRAC_BITS - 30);
        end
        if (w > 64'sd2147483647) begin
            r = '{1'b1, 64'sd2147483647};
        end else if (w < -64'sd2147483648) begin
            r = '{1'b1, -64'sd2147483648};
        end else begin
            r = '{1'b0, w};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/csp_ifs.sv -----
// Valid/ready channel interfaces of the Cayley spin precession block:
// request, response and configuration write. No dependencies.
`default_nettype none

interface csp_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;

    modport source (output valid, req_type, spin_x, spin_y, spin_z,
                    axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, req_type, spin_x, spin_y, spin_z,
                    axis_x, axis_y, axis_z, output ready);
endinterface

interface csp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] final_x;
    logic signed [31:0] final_y;
    logic signed [31:0] final_z;
    logic               saturated;

    modport source (output valid, final_x, final_y, final_z, saturated, input ready);
    modport sink   (input valid, final_x, final_y, final_z, saturated, output ready);
endinterface

interface csp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/csp_mul.sv -----
// Shared 64x64 fixed-point multiplier: four 32x32 partial products, one per cycle,
// then round, saturate and sign. Depends on csp_pkg.
`default_nettype none

module csp_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  csp_pkg::mul_req_t cmd,
    output csp_pkg::mul_rsp_t res
);
    import csp_pkg::*;

    logic                  busy_reg, busy_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [WORD_W-1:0]     ma_reg, ma_next, mb_reg, mb_next;
    logic                  neg_reg, neg_next;
    logic [WORD_W-1:0]     pp_reg, pp_next;
    logic [1:0]            sh_reg, sh_next;
    logic [2*WORD_W-1:0]   acc_reg, acc_next;
    word_t                 p_reg, p_next;
    logic                  sat_reg, sat_next;

    logic [31:0]           a_part, b_part;
    logic [2*WORD_W-1:0]   q_wide;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        p_next    = p_reg;
        sat_next  = sat_reg;
        a_part    = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        b_part    = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        q_wide    = acc_reg >> FRAC_BITS;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            ma_next   = cmd.a[WORD_W-1] ? (~cmd.a + 64'd1) : cmd.a;
            mb_next   = cmd.b[WORD_W-1] ? (~cmd.b + 64'd1) : cmd.b;
            neg_next  = cmd.a[WORD_W-1] ^ cmd.b[WORD_W-1];
            acc_next  = (2*WORD_W)'(1) << (FRAC_BITS - 1);
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg < 3'd4) begin
                pp_next = WORD_W'(a_part) * WORD_W'(b_part);
                sh_next = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                acc_next = acc_reg + ({{WORD_W{1'b0}}, pp_reg} << {sh_reg, 5'b0});
            end
            if (cnt_reg == 3'd5) begin
                busy_next = 1'b0;
                sat_next  = |q_wide[2*WORD_W-1:WORD_W-1];
                if (sat_next) begin
                    p_next = neg_reg ? -WMAX : WMAX;
                end else begin
                    p_next = neg_reg ? -$signed(q_wide[WORD_W-1:0])
                                     : $signed(q_wide[WORD_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
        sat_reg <= sat_next;
    end

    assign res = '{busy_reg, sat_reg, p_reg};

endmodule

`default_nettype wire

// ----- src/csp_div.sv -----
// Shared unsigned 64/64 restoring divider, one quotient bit per cycle.
// Depends on csp_pkg.
`default_nettype none

module csp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  csp_pkg::div_req_t cmd,
    output csp_pkg::div_rsp_t res
);
    import csp_pkg::*;

    logic              busy_reg, busy_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [WORD_W-1:0] n_reg, n_next, d_reg, d_next, r_reg, r_next, q_reg, q_next;
    logic [WORD_W-1:0] r_shift;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        r_shift   = {r_reg[WORD_W-2:0], n_reg[WORD_W-1]};
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            n_next    = cmd.n;
            d_next    = cmd.d;
            r_next    = '0;
            q_next    = '0;
        end else if (busy_reg) begin
            n_next = {n_reg[WORD_W-2:0], 1'b0};
            if (r_shift >= d_reg) begin
                r_next = r_shift - d_reg;
                q_next = {q_reg[WORD_W-2:0], 1'b1};
            end else begin
                r_next = r_shift;
                q_next = {q_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        n_reg <= n_next;
        d_reg <= d_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign res = '{busy_reg, q_reg};

endmodule

`default_nettype wire

// ----- src/cayley_spin_precession.sv -----
// Top level of the Cayley spin precession block: sequencer, register file,
// configuration registers and output register. Depends on csp_pkg, csp_ifs,
// csp_mul and csp_div.
//
//   channel | dir | payload                                   | accepted when
//   req     | in  | req_type, spin_x/y/z, axis_x/y/z          | valid && ready
//   rsp     | out | final_x/y/z, saturated                    | valid && ready
//   cfg     | in  | index (0 gain, 1 total_time, 2 substeps)  | valid && ready
//
// One request runs K substeps, K the clamped substep count (256 at the reset
// value). Per substep, 22 products in self mode and 21 in axis mode on the shared
// multiplier, each with register-file read and write-back, 15 add/subtract steps
// and one reciprocal on the bit-serial divider make up the work.
// Reset clears control state and loads the configuration reset values.
// req is held off while a request is in flight; a finished result waits in the
// output register, and the next result holds until it is taken.
`default_nettype none

module cayley_spin_precession #(
    parameter int unsigned MAX_SUBSTEPS = csp_pkg::DEF_MAX_SUBSTEPS
) (
    input  logic      clk,
    input  logic      rst_n,
    csp_in_if.sink    req,
    csp_out_if.source rsp,
    csp_cfg_if.sink   cfg
);
    import csp_pkg::*;

    localparam int CW = $clog2(MAX_SUBSTEPS + 1);

    // configuration
    logic signed [31:0] gain_reg;
    logic [31:0]        total_time_reg;
    logic [12:0]        substep_count_reg;

    // sequencer state
    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [CW-1:0]   sub_cnt_reg, sub_cnt_next;
    logic [CW-1:0]   kcount_reg, kcount_next;
    logic [2:0]      load_cnt_reg, load_cnt_next;
    logic [1:0]      out_idx_reg, out_idx_next;
    logic            sat_reg, sat_next;
    logic            out_valid_reg, out_valid_next;

    // request capture
    logic               self_reg;
    logic signed [31:0] spin_reg [3];
    logic signed [31:0] axis_reg [3];

    logic signed [31:0] res_reg [3];
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic               fsat_reg;

    // register file
    word_t     rf_mem [REG_COUNT];
    word_t     rd_a_reg, rd_b_reg;
    reg_addr_t rd_addr_a, rd_addr_b;
    logic      wr_en;
    reg_addr_t wr_addr;
    word_t     wr_data;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    uop_t        uop;
    sres_t       alu;
    sres_t       outq;
    logic        req_acc, rsp_acc, cfg_acc;
    logic        step_done, last_op, last_sub, can_emit;
    int unsigned kc;

    assign req_acc = req.valid && req.ready;
    assign rsp_acc = rsp.valid && rsp.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);

    assign uop      = prog_rom(pc_reg);
    assign last_op  = (pc_reg == PC_LAST);
    assign last_sub = (sub_cnt_reg == kcount_reg - CW'(1));
    assign can_emit = !out_valid_reg || rsp.ready;
    assign outq     = to_q230(rd_a_reg);

    // Clamp the substep count: zero runs one substep, large values stop at the maximum.
    always_comb begin
        if (substep_count_reg == 13'd0) begin
            kc = 1;
        end else if (32'(substep_count_reg) > MAX_SUBSTEPS) begin
            kc = MAX_SUBSTEPS;
        end else begin
            kc = 32'(substep_count_reg);
        end
        kcount_next = CW'(kc);
    end

    // Saturating add/subtract for the add, subtract and add-one micro-ops.
    always_comb begin
        case (uop.op)
            OP_SUB:  alu = sadd(rd_a_reg, -rd_b_reg);
            OP_ADD1: alu = sadd(rd_a_reg, ONE);
            default: alu = sadd(rd_a_reg, rd_b_reg);
        endcase
    end

    always_comb begin
        step_done = 1'b0;
        if (state_reg == ST_EXEC && uop.op != OP_MUL && uop.op != OP_DIV) begin
            step_done = 1'b1;
        end
        if (state_reg == ST_MUL_WAIT && !mul_rsp.busy) begin
            step_done = 1'b1;
        end
        if (state_reg == ST_DIV_WAIT && !div_rsp.busy) begin
            step_done = 1'b1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (req_acc) state_next = ST_LOAD;
            ST_LOAD:    if (load_cnt_reg == 3'd6) state_next = ST_HH_WAIT;
            ST_HH_WAIT: if (!div_rsp.busy) state_next = ST_ISSUE;
            ST_ISSUE:   state_next = ST_EXEC;
            ST_EXEC: begin
                if (uop.op == OP_MUL) begin
                    state_next = ST_MUL_WAIT;
                end else if (uop.op == OP_DIV) begin
                    state_next = ST_DIV_WAIT;
                end else begin
                    state_next = (last_op && last_sub) ? ST_OUT_RD : ST_ISSUE;
                end
            end
            ST_MUL_WAIT, ST_DIV_WAIT: begin
                if (step_done) begin
                    state_next = (last_op && last_sub) ? ST_OUT_RD : ST_ISSUE;
                end
            end
            ST_OUT_RD:  state_next = ST_OUT_CAP;
            ST_OUT_CAP: state_next = (out_idx_reg == 2'd2) ? ST_DONE : ST_OUT_RD;
            ST_DONE:    if (can_emit) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit requests and register-file ports
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = uop.dst;
        wr_data   = alu.val;
        rd_addr_a = uop.sa;
        rd_addr_b = uop.sb;
        mul_req   = '{1'b0, rd_a_reg, rd_b_reg};
        div_req   = '{1'b0, RECIP_NUM, rd_a_reg};
        if (req_acc) begin
            // half step: floor(T / 2K) in working units
            div_req = '{1'b1, to_work({32'b0, total_time_reg}, 28),
                        {{(WORD_W-CW-1){1'b0}}, kcount_next, 1'b0}};
        end
        unique case (state_reg)
            ST_LOAD: begin
                wr_en = 1'b1;
                unique case (load_cnt_reg)
                    3'd0:    begin wr_addr = R_B0;  wr_data = to_work(word_t'(spin_reg[0]), 30); end
                    3'd1:    begin wr_addr = R_B1;  wr_data = to_work(word_t'(spin_reg[1]), 30); end
                    3'd2:    begin wr_addr = R_B2;  wr_data = to_work(word_t'(spin_reg[2]), 30); end
                    3'd3:    begin wr_addr = R_OM0;
                                   wr_data = self_reg ? '0 : to_work(word_t'(axis_reg[0]), 28); end
                    3'd4:    begin wr_addr = R_OM1;
                                   wr_data = self_reg ? '0 : to_work(word_t'(axis_reg[1]), 28); end
                    3'd5:    begin wr_addr = R_OM2;
                                   wr_data = self_reg ? '0 : to_work(word_t'(axis_reg[2]), 28); end
                    default: begin wr_addr = R_G;   wr_data = to_work(word_t'(gain_reg), 28); end
                endcase
            end
            ST_HH_WAIT: begin
                wr_en   = !div_rsp.busy;
                wr_addr = R_HH;
                wr_data = $signed(div_rsp.q);
            end
            ST_EXEC: begin
                mul_req.start = (uop.op == OP_MUL);
                div_req.start = (uop.op == OP_DIV);
                wr_en = (uop.op != OP_MUL) && (uop.op != OP_DIV);
            end
            ST_MUL_WAIT: begin
                wr_en   = !mul_rsp.busy;
                wr_data = mul_rsp.p;
            end
            ST_DIV_WAIT: begin
                wr_en   = !div_rsp.busy;
                wr_data = $signed(div_rsp.q);
            end
            ST_OUT_RD: begin
                unique case (out_idx_reg)
                    2'd0:    rd_addr_a = R_B0;
                    2'd1:    rd_addr_a = R_B1;
                    default: rd_addr_a = R_B2;
                endcase
            end
            default: begin
            end
        endcase
    end

    // sequencer counters, flag and output register
    always_comb begin
        pc_next        = pc_reg;
        sub_cnt_next   = sub_cnt_reg;
        load_cnt_next  = load_cnt_reg;
        out_idx_next   = out_idx_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        if (rsp_acc) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                load_cnt_next = 3'd0;
                if (req_acc) sat_next = 1'b0;
            end
            ST_LOAD: load_cnt_next = load_cnt_reg + 3'd1;
            ST_HH_WAIT: begin
                pc_next      = self_reg ? PC_SELF : PC_AXIS;
                sub_cnt_next = '0;
            end
            ST_EXEC: begin
                if (step_done) sat_next = sat_reg | alu.sat;
            end
            ST_MUL_WAIT: begin
                if (step_done) sat_next = sat_reg | mul_rsp.sat;
            end
            ST_OUT_RD: begin
            end
            ST_OUT_CAP: begin
                sat_next     = sat_reg | outq.sat;
                out_idx_next = out_idx_reg + 2'd1;
            end
            ST_DONE: begin
                if (can_emit) out_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_OUT_RD && out_idx_reg == 2'd0 && pc_reg == PC_LAST) begin
            out_idx_next = 2'd0;
        end
        if (step_done) begin
            if (last_op) begin
                pc_next = self_reg ? PC_SELF : PC_AXIS;
                if (!last_sub) sub_cnt_next = sub_cnt_reg + CW'(1);
                out_idx_next = 2'd0;
            end else begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg         <= ST_IDLE;
            pc_reg            <= PC_SELF;
            sub_cnt_reg       <= '0;
            load_cnt_reg      <= 3'd0;
            out_idx_reg       <= 2'd0;
            sat_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            gain_reg          <= GAIN_RESET;
            total_time_reg    <= TIME_RESET;
            substep_count_reg <= SUBSTEPS_RESET;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sub_cnt_reg   <= sub_cnt_next;
            load_cnt_reg  <= load_cnt_next;
            out_idx_reg   <= out_idx_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cfg_acc) begin
                case (cfg.index)
                    CFG_GAIN:          gain_reg          <= $signed(cfg.data);
                    CFG_TOTAL_TIME:    total_time_reg    <= cfg.data;
                    CFG_SUBSTEP_COUNT: substep_count_reg <= cfg.data[12:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers: capture the request, hold results, drive the output
    always_ff @(posedge clk) begin
        if (req_acc) begin
            self_reg    <= !req.req_type;
            kcount_reg  <= kcount_next;
            spin_reg[0] <= req.spin_x;
            spin_reg[1] <= req.spin_y;
            spin_reg[2] <= req.spin_z;
            axis_reg[0] <= req.axis_x;
            axis_reg[1] <= req.axis_y;
            axis_reg[2] <= req.axis_z;
        end
        if (state_reg == ST_OUT_CAP) begin
            res_reg[out_idx_reg] <= outq.val[31:0];
        end
        if (state_reg == ST_DONE && can_emit) begin
            fx_reg   <= res_reg[0];
            fy_reg   <= res_reg[1];
            fz_reg   <= res_reg[2];
            fsat_reg <= sat_reg;
        end
    end

    // register file: one write port, two registered read ports
    always_ff @(posedge clk) begin
        if (wr_en) begin
            rf_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= rf_mem[rd_addr_a];
        rd_b_reg <= rf_mem[rd_addr_b];
    end

    csp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_req),
        .res   (mul_rsp)
    );

    csp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_req),
        .res   (div_rsp)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.final_x   = fx_reg;
    assign rsp.final_y   = fy_reg;
    assign rsp.final_z   = fz_reg;
    assign rsp.saturated = fsat_reg;

    // a product request never lands on a multiplier still at work
    assert property (@(posedge clk) disable iff (!rst_n) mul_req.start |-> !mul_rsp.busy)
        else $error("multiply started while the multiplier is busy");

    // a division request never lands on a divider still at work
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
        else $error("divide started while the divider is busy");

    // an accepted request holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n) req_acc |=> !req.ready)
        else $error("request taken while another is in flight");

    // a finished result waits while the output register is still full
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rsp.valid && !rsp.ready) |=> state_reg == ST_DONE)
        else $error("result dropped over a stalled response");

endmodule

`default_nettype wire

// ----- tb/sv/tb_cayley_spin_precession.sv -----
// Self-checking testbench for cayley_spin_precession: drives requests and register
// writes, predicts each precessed spin vector in fixed point and checks every response.
// Depends on csp_pkg, csp_ifs and the block's RTL.

module tb_cayley_spin_precession;

    typedef logic signed [63:0] word_t;

    localparam word_t     WORD_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic      MODE_SELF  = 1'b0;
    localparam logic      MODE_AXIS  = 1'b1;
    localparam int        STEP_CLAMP = 4096;
    localparam longint    CYCLE_LIMIT = 8_000_000;

    typedef struct {
        logic               mode;
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] ax, ay, az;
    } spin_req_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               sat;
    } spin_res_t;

    // Holds expected precessed vectors in request order and checks responses.
    class spin_scoreboard;
        spin_res_t pending_q[$];
        int        errors;

        function void note_request(spin_res_t exp_res);
            pending_q.push_back(exp_res);
        endfunction

        function void check_result(spin_res_t got);
            spin_res_t want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response x=%h y=%h z=%h sat=%b",
                             got.x, got.y, got.z, got.sat);
                return;
            end
            want = pending_q.pop_front();
            if (want.x !== got.x || want.y !== got.y || want.z !== got.z
                || want.sat !== got.sat) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                             want.x, want.y, want.z, want.sat,
                             got.x, got.y, got.z, got.sat);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csp_in_if  req_if ();
    csp_out_if rsp_if ();
    csp_cfg_if cfg_if ();

    cayley_spin_precession dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #2 clk = ~clk;

    spin_scoreboard sb = new();

    // shadow copy of the block's registers
    logic signed [31:0] gain_q     = csp_pkg::GAIN_RESET;
    logic [31:0]        time_q     = csp_pkg::TIME_RESET;
    logic [12:0]        substeps_q = csp_pkg::SUBSTEPS_RESET;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    logic sat_seen;
    longint cycle_count = 0;

    // ---------------------------------------------------------------
    // Fixed-point predictor: 64-bit working values with 30 fraction
    // bits, saturating sums and rounded products.
    // ---------------------------------------------------------------
    function automatic word_t sat_add(word_t a, word_t b);
        logic signed [64:0] s;
        logic signed [64:0] lim;
        lim = $signed({1'b0, WORD_MAX});
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > lim) begin
            sat_seen = 1'b1;
            return WORD_MAX;
        end
        if (s < -lim) begin
            sat_seen = 1'b1;
            return -WORD_MAX;
        end
        return s[63:0];
    endfunction

    // product rounded to nearest, ties away from zero
    function automatic word_t fx_mul(word_t a, word_t b);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        logic         neg;
        neg = a[63] ^ b[63];
        ma  = a[63] ? -a : a;
        mb  = b[63] ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        p   = p + (128'd1 << 29);
        if (p[127:93] != 0) begin
            sat_seen = 1'b1;
            return neg ? -WORD_MAX : WORD_MAX;
        end
        return neg ? -$signed(p[93:30]) : $signed(p[93:30]);
    endfunction

    function automatic void cross3(input word_t a[3], input word_t b[3], output word_t c[3]);
        c[0] = sat_add(fx_mul(a[1], b[2]), -fx_mul(a[2], b[1]));
        c[1] = sat_add(fx_mul(a[2], b[0]), -fx_mul(a[0], b[2]));
        c[2] = sat_add(fx_mul(a[0], b[1]), -fx_mul(a[1], b[0]));
    endfunction

    function automatic logic signed [31:0] to_spin_word(word_t v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic spin_res_t precess_spin(spin_req_t r);
        word_t     b[3], om[3], k[3], c[3], d[3];
        word_t     g, hh, kk, s, den;
        int        kc;
        spin_res_t res;
        sat_seen = 1'b0;
        kc = (substeps_q == 0) ? 1 : (substeps_q > STEP_CLAMP) ? STEP_CLAMP : substeps_q;
        b[0] = r.sx;
        b[1] = r.sy;
        b[2] = r.sz;
        g    = {{30{gain_q[31]}}, gain_q, 2'b00};
        hh   = $signed({30'd0, time_q, 2'b00}) / word_t'(2 * kc);
        for (int i = 0; i < kc; i++) begin
            if (r.mode == MODE_SELF) begin
                om[0] = 0;
                om[1] = 0;
                om[2] = fx_mul(g, b[2]);
            end else begin
                om[0] = {{30{r.ax[31]}}, r.ax, 2'b00};
                om[1] = {{30{r.ay[31]}}, r.ay, 2'b00};
                om[2] = {{30{r.az[31]}}, r.az, 2'b00};
            end
            for (int j = 0; j < 3; j++) k[j] = fx_mul(om[j], hh);
            kk  = sat_add(sat_add(fx_mul(k[0], k[0]), fx_mul(k[1], k[1])), fx_mul(k[2], k[2]));
            den = sat_add(64'sd1 <<< 30, kk);
            s   = $signed(64'h2000_0000_0000_0000 / $unsigned(den));
            cross3(k, b, c);
            cross3(k, c, d);
            for (int j = 0; j < 3; j++) b[j] = sat_add(b[j], fx_mul(s, sat_add(c[j], d[j])));
        end
        res.x   = to_spin_word(b[0]);
        res.y   = to_spin_word(b[1]);
        res.z   = to_spin_word(b[2]);
        res.sat = sat_seen;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic send_request(spin_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= r.mode;
        req_if.spin_x   <= r.sx;
        req_if.spin_y   <= r.sy;
        req_if.spin_z   <= r.sz;
        req_if.axis_x   <= r.ax;
        req_if.axis_y   <= r.ay;
        req_if.axis_z   <= r.az;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(precess_spin(r));
    endtask

    // drop the request, then wait for every outstanding response
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(csp_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            csp_pkg::CFG_GAIN:       gain_q     = value;
            csp_pkg::CFG_TOTAL_TIME: time_q     = value;
            default:                 substeps_q = value[12:0];
        endcase
    endtask

    function automatic spin_req_t make_req(logic mode, int sx, int sy, int sz,
                                           int ax, int ay, int az);
        spin_req_t r;
        r.mode = mode;
        r.sx = sx; r.sy = sy; r.sz = sz;
        r.ax = ax; r.ay = ay; r.az = az;
        return r;
    endfunction

    // mostly physical values near the unit sphere, sometimes any bit pattern
    function automatic logic signed [31:0] rand_field(logic [31:0] span);
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * span)) - $signed(span);
    endfunction

    function automatic spin_req_t rand_req();
        spin_req_t r;
        r.mode = $urandom_range(1);
        r.sx = rand_field(32'h4000_0000);
        r.sy = rand_field(32'h4000_0000);
        r.sz = rand_field(32'h4000_0000);
        r.ax = rand_field(32'h2000_0000);
        r.ay = rand_field(32'h2000_0000);
        r.az = rand_field(32'h2000_0000);
        return r;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return rand_field(32'h3000_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h2000_0000);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Response side: random stalls plus an optional long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        spin_res_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.x   = rsp_if.final_x;
            got.y   = rsp_if.final_y;
            got.z   = rsp_if.final_z;
            got.sat = rsp_if.saturated;
            sb.check_result(got);
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cayley_spin_precession verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        req_if.valid    = 1'b0;
        req_if.req_type = MODE_SELF;
        req_if.spin_x   = '0;
        req_if.spin_y   = '0;
        req_if.spin_z   = '0;
        req_if.axis_x   = '0;
        req_if.axis_y   = '0;
        req_if.axis_z   = '0;
        rsp_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = csp_pkg::CFG_GAIN;
        cfg_if.data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, one request per mode
        send_request(make_req(MODE_SELF, 32'h2000_0000, 32'h0, 32'h3000_0000, 0, 0, 0));
        send_request(make_req(MODE_AXIS, 32'h4000_0000, 32'h0, 32'h0, 0, 0, 32'h1000_0000));
        drain();

        // directed: field extremes, both modes, saturation; one substep keeps it short
        write_reg(csp_pkg::CFG_GAIN, 32'h1000_0000);
        write_reg(csp_pkg::CFG_TOTAL_TIME, 32'h1000_0000);
        write_reg(csp_pkg::CFG_SUBSTEP_COUNT, 32'd1);
        send_request(make_req(MODE_SELF, 0, 0, 0, 0, 0, 0));
        send_request(make_req(MODE_SELF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        send_request(make_req(MODE_SELF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        // axis fields are ignored in self mode
        send_request(make_req(MODE_SELF, 32'h4000_0000, 0, 32'h4000_0000,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678));
        send_request(make_req(MODE_AXIS, 32'h4000_0000, 0, 0, 0, 0, 0));
        send_request(make_req(MODE_AXIS, 32'h4000_0000, 32'h4000_0000, 0,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_req(MODE_AXIS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(make_req(MODE_AXIS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_request(make_req(MODE_AXIS, 32'h2000_0000, 32'hE000_0000, 32'h1000_0000,
                              32'h1000_0000, 32'hF000_0000, 32'h0800_0000));
        drain();
        write_reg(csp_pkg::CFG_GAIN, 32'h8000_0000);
        write_reg(csp_pkg::CFG_TOTAL_TIME, 32'hFFFF_FFFF);
        write_reg(csp_pkg::CFG_SUBSTEP_COUNT, 32'd2);
        send_request(make_req(MODE_SELF, 32'h4000_0000, 0, 32'h4000_0000, 0, 0, 0));
        send_request(make_req(MODE_AXIS, 32'h4000_0000, 0, 0, 32'h1000_0000, 0, 0));
        drain();
        write_reg(csp_pkg::CFG_GAIN, 32'h7FFF_FFFF);
        write_reg(csp_pkg::CFG_TOTAL_TIME, 32'h0);
        send_request(make_req(MODE_SELF, 32'h4000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0));
        send_request(make_req(MODE_AXIS, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0));
        drain();

        // random phases, one per idling pattern
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            write_reg(csp_pkg::CFG_GAIN, pick_gain());
            write_reg(csp_pkg::CFG_TOTAL_TIME, pick_time());
            write_reg(csp_pkg::CFG_SUBSTEP_COUNT, $urandom_range(1, 4));
            // hold the response side off so the block backs up and stalls requests
            if (p == 2) hold_left = 5000;
            for (int n = 0; n < 22; n++) send_request(rand_req());
            drain();
        end

        // substep count corner cases: zero runs one step, above the cap clamps
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(csp_pkg::CFG_GAIN, csp_pkg::GAIN_RESET);
        write_reg(csp_pkg::CFG_TOTAL_TIME, csp_pkg::TIME_RESET);
        write_reg(csp_pkg::CFG_SUBSTEP_COUNT, 32'd0);
        for (int n = 0; n < 3; n++) send_request(rand_req());
        drain();
        write_reg(csp_pkg::CFG_SUBSTEP_COUNT, 32'h1FFF);
        send_request(make_req(MODE_AXIS, 32'h4000_0000, 0, 0, 0, 0, 32'h1000_0000));
        drain();
        repeat (200) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("cayley_spin_precession verification clean");
        else
            $display("cayley_spin_precession verification failed");
        $finish;
    end

endmodule
